FILE: hdl/fbpa_pkg.sv
// Shared types, codes and constants of the fixed block pool allocator.
package fbpa_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int ADDR_BITS_DEF   = 64;

    localparam int FREE_ADDR_W   = 64;
    localparam int BLOCK_ADDR_W  = 64;
    localparam int STATUS_W      = 2;
    localparam int FREE_BLOCKS_W = 11;
    localparam int BLK_BYTES_W   = 32;
    localparam int BLOCK_COUNT_W = 11;
    localparam int POOL_BASE_W   = 64;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_LSB    = 3;
    localparam int REG_IDX_W  = 2;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POOL_BASE   = 2'd0,
        REG_BLK_BYTES   = 2'd1,
        REG_BLOCK_COUNT = 2'd2
    } reg_idx_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_POOL = 2'd1,
        SRC_MEM  = 2'd2
    } src_t;

    typedef struct packed {
        logic [POOL_BASE_W-1:0]   pool_base;
        logic [BLK_BYTES_W-1:0]   blk_bytes;
        logic [BLOCK_COUNT_W-1:0] block_count;
        logic                     rebuild;
    } cfg_t;

endpackage

FILE: hdl/fbpa_cfg.sv
// Configuration register file with an APB-style write and read port.
module fbpa_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbpa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fbpa_pkg::CFG_DATA_W-1:0]     prdata,
    output fbpa_pkg::cfg_t                      cfg
);

    logic [fbpa_pkg::POOL_BASE_W-1:0]   pool_base_reg;
    logic [fbpa_pkg::BLK_BYTES_W-1:0]   blk_bytes_reg;
    logic [fbpa_pkg::BLOCK_COUNT_W-1:0] block_count_reg;
    logic                               rebuild_reg;
    logic                               wr_en;
    fbpa_pkg::reg_idx_t                 idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = fbpa_pkg::reg_idx_t'(paddr[fbpa_pkg::CFG_ADDR_W-1:fbpa_pkg::REG_LSB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg   <= '0;
            blk_bytes_reg   <= fbpa_pkg::BLK_BYTES_W'(4096);
            block_count_reg <= '0;
            rebuild_reg     <= 1'b0;
        end else begin
            rebuild_reg <= 1'b0;
            if (wr_en) begin
                unique case (idx)
                    fbpa_pkg::REG_POOL_BASE: begin
                        pool_base_reg <= pwdata;
                        rebuild_reg   <= 1'b1;
                    end
                    fbpa_pkg::REG_BLK_BYTES: begin
                        blk_bytes_reg <= pwdata[fbpa_pkg::BLK_BYTES_W-1:0];
                        rebuild_reg   <= 1'b1;
                    end
                    fbpa_pkg::REG_BLOCK_COUNT: begin
                        block_count_reg <= pwdata[fbpa_pkg::BLOCK_COUNT_W-1:0];
                        rebuild_reg     <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            fbpa_pkg::REG_POOL_BASE:   prdata = pool_base_reg;
            fbpa_pkg::REG_BLK_BYTES:   prdata = fbpa_pkg::CFG_DATA_W'(blk_bytes_reg);
            fbpa_pkg::REG_BLOCK_COUNT: prdata = fbpa_pkg::CFG_DATA_W'(block_count_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.pool_base   = pool_base_reg;
    assign cfg.blk_bytes   = blk_bytes_reg;
    assign cfg.block_count = block_count_reg;
    assign cfg.rebuild     = rebuild_reg;

endmodule

FILE: hdl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: FIFO free list in one memory.
//
//  channel  | direction | fields
//  ---------+-----------+-----------------------------------------------
//  s_       | in        | tuser: cmd; tdata: free_address
//  m_       | out       | tuser: status; tdata: block_address, free_blocks
//  APB      | in/out    | pool_base @0x00, blk_bytes @0x08, block_count @0x10
//
//  One item per cycle while the result is not stalled and no rebuild is under way;
//  the queue memory read and the block offset product fill the first stage, the
//  address add the second. A stalled result holds both stages. Pool blocks not
//  yet handed out come from base + index * size, so a rebuild needs no fill of
//  the memory; reset needs no clearing pass.
module fixed_block_pool_allocator #(
    parameter int QUEUE_DEPTH = fbpa_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_BITS   = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fbpa_pkg::S_TDATA_W-1:0]      s_tdata,  // [63:0] free_address
    input  logic [fbpa_pkg::S_TUSER_W-1:0]      s_tuser,  // [0] cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fbpa_pkg::M_TDATA_W-1:0]      m_tdata,  // [63:0] block_address, [74:64] free_blocks
    output logic [fbpa_pkg::M_TUSER_W-1:0]      m_tuser,  // [1:0] status
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbpa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fbpa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W = PTR_W + fbpa_pkg::BLK_BYTES_W;
    localparam int PAD_W  = fbpa_pkg::M_TDATA_W - fbpa_pkg::BLOCK_ADDR_W
                            - fbpa_pkg::FREE_BLOCKS_W;

    fbpa_pkg::cfg_t cfg;

    fbpa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    logic [ADDR_BITS-1:0] mem [QUEUE_DEPTH];
    logic [ADDR_BITS-1:0] rd_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pool_reg, pool_next;
    logic [CNT_W-1:0] orig_reg, orig_next;

    logic                a_valid_reg;
    fbpa_pkg::status_t   a_status_reg, a_status_next;
    fbpa_pkg::src_t      a_src_reg, a_src_next;
    logic [PROD_W-1:0]   a_prod_reg;
    logic [CNT_W-1:0]    a_count_reg;

    logic                                  m_valid_reg;
    logic [fbpa_pkg::BLOCK_ADDR_W-1:0]     m_addr_reg, m_addr_next;
    fbpa_pkg::status_t                     m_status_reg;
    logic [fbpa_pkg::FREE_BLOCKS_W-1:0]    m_free_reg;

    logic             advance, accept, mem_re, mem_we;
    fbpa_pkg::cmd_t   cmd;
    logic [31:0]      n_wide;
    logic [CNT_W-1:0] n_clamp;
    logic [ADDR_BITS-1:0] pool_addr;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance && !cfg.rebuild;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = fbpa_pkg::cmd_t'(s_tuser[0]);

    assign n_wide  = 32'(cfg.block_count);
    assign n_clamp = (n_wide > 32'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(n_wide);

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        pool_next     = pool_reg;
        orig_next     = orig_reg;
        a_status_next = fbpa_pkg::STATUS_DONE;
        a_src_next    = fbpa_pkg::SRC_ZERO;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        if (cfg.rebuild) begin
            head_next  = '0;
            tail_next  = (n_clamp == CNT_W'(QUEUE_DEPTH)) ? '0 : PTR_W'(n_clamp);
            count_next = n_clamp;
            pool_next  = n_clamp;
            orig_next  = n_clamp;
        end else if (accept) begin
            unique case (cmd)
                fbpa_pkg::CMD_ALLOC: begin
                    if (count_reg == '0) begin
                        a_status_next = fbpa_pkg::STATUS_EMPTY;
                    end else begin
                        head_next  = ptr_inc(head_reg);
                        count_next = count_reg - CNT_W'(1);
                        if (orig_reg != '0) begin
                            orig_next  = orig_reg - CNT_W'(1);
                            a_src_next = fbpa_pkg::SRC_POOL;
                        end else begin
                            mem_re     = 1'b1;
                            a_src_next = fbpa_pkg::SRC_MEM;
                        end
                    end
                end
                fbpa_pkg::CMD_FREE: begin
                    if (count_reg >= pool_reg) begin
                        a_status_next = fbpa_pkg::STATUS_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= s_tdata[ADDR_BITS-1:0];
        end
        if (mem_re) begin
            rd_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            pool_reg    <= '0;
            orig_reg    <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            pool_reg  <= pool_next;
            orig_reg  <= orig_next;
            if (advance) begin
                a_valid_reg <= accept;
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_status_reg <= a_status_next;
            a_src_reg    <= a_src_next;
            a_prod_reg   <= PROD_W'(head_reg) * PROD_W'(cfg.blk_bytes);
            a_count_reg  <= count_next;
        end
        if (advance && a_valid_reg) begin
            m_addr_reg   <= m_addr_next;
            m_status_reg <= a_status_reg;
            m_free_reg   <= fbpa_pkg::FREE_BLOCKS_W'(a_count_reg);
        end
    end

    assign pool_addr = ADDR_BITS'(cfg.pool_base + fbpa_pkg::POOL_BASE_W'(a_prod_reg));

    always_comb begin
        unique case (a_src_reg)
            fbpa_pkg::SRC_POOL: m_addr_next = fbpa_pkg::BLOCK_ADDR_W'(pool_addr);
            fbpa_pkg::SRC_MEM:  m_addr_next = fbpa_pkg::BLOCK_ADDR_W'(rd_reg);
            default:            m_addr_next = '0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_free_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

endmodule

FILE: hdl/fbpa_checker.sv
// Port-level checks of the fixed block pool allocator and their bind.
module fbpa_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [fbpa_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [fbpa_pkg::M_TUSER_W-1:0]   m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted item produced no result");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == fbpa_pkg::STATUS_EMPTY)
        |-> (m_tdata[63:0] == '0) && (m_tdata[74:64] == '0))
        else $error("empty result with address or free blocks");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == fbpa_pkg::STATUS_FULL)
        |-> (m_tdata[63:0] == '0) && (m_tdata[79:75] == '0))
        else $error("full result with nonzero address");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
